FILE: hdl/gpat_pkg.sv
package gpat_pkg;

   // action codes of a request transaction
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // port has four timing bits and four position inputs
   localparam int unsigned INPUT_AXES  = 4;
   localparam logic [3:0]  FLAG_NIBBLE = 4'hf;

   // one-shot counter and load arithmetic widths
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned ACC_W   = 21;
   localparam int unsigned COEF_W  = 22;
   localparam int unsigned PROD_W  = ACC_W + COEF_W;
   localparam int unsigned SHIFT_W = 5;

   localparam logic [COUNT_W-1:0] TICK_BIAS = 11'd24;

   // steps of the load calculation, one multiply each
   typedef enum logic [1:0] {
      STEP_SCALE,
      STEP_DIV13,
      STEP_MUL11,
      STEP_DIV1000
   } step_type;

   // top level sequencer
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_LOAD,
      CTL_WAIT,
      CTL_RESP
   } ctl_state_type;

   // multiplier constant per step
   // *100/65 is *20/13; /13 and /1000 are exact reciprocal multiplies over the value range
   function automatic logic [COEF_W-1:0] step_coef(input step_type step);
      logic [COEF_W-1:0] coef;
      case (step)
         STEP_SCALE:   coef = 22'd20;
         STEP_DIV13:   coef = 22'd2581111;
         STEP_MUL11:   coef = 22'd11;
         STEP_DIV1000: coef = 22'd2147484;
         default:      coef = '0;
      endcase
      return coef;
   endfunction

   // right shift applied to the product per step
   function automatic logic [SHIFT_W-1:0] step_shift(input step_type step);
      logic [SHIFT_W-1:0] amount;
      case (step)
         STEP_DIV13:   amount = 5'd25;
         STEP_DIV1000: amount = 5'd31;
         default:      amount = 5'd0;
      endcase
      return amount;
   endfunction

endpackage

FILE: hdl/gpat_ifs.sv
interface gpat_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] axis0_position;
   logic signed [15:0] axis1_position;
   logic signed [15:0] axis2_position;
   logic signed [15:0] axis3_position;
   logic [3:0]         present_mask;
   logic [7:0]         joystick_byte;

   modport source (
      output valid, action, axis0_position, axis1_position, axis2_position,
             axis3_position, present_mask, joystick_byte,
      input  ready
   );
   modport sink (
      input  valid, action, axis0_position, axis1_position, axis2_position,
             axis3_position, present_mask, joystick_byte,
      output ready
   );
endinterface

interface gpat_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [3:0] timing_bits;

   modport source (output valid, read_data, timing_bits, input ready);
   modport sink (input valid, read_data, timing_bits, output ready);
endinterface

FILE: hdl/gpat_load_unit.sv
module gpat_load_unit
   import gpat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] position,
   output logic               done,
   output logic [COUNT_W-1:0] load_value
);

   step_type           step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0] load_ff, load_in;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  scaled;

   // shared multiplier and product shift
   assign prod   = PROD_W'(acc_ff) * PROD_W'(step_coef(step_ff));
   assign scaled = prod >> step_shift(step_ff);

   // step sequencer
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      load_in = load_ff;
      if (start) begin
         // adding 32768 flips the sign bit
         acc_in  = ACC_W'({~position[15], position[14:0]});
         step_in = STEP_SCALE;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = scaled[ACC_W-1:0];
         case (step_ff)
            STEP_SCALE: step_in = STEP_DIV13;
            STEP_DIV13: step_in = STEP_MUL11;
            STEP_MUL11: step_in = STEP_DIV1000;
            STEP_DIV1000: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               load_in = scaled[COUNT_W-1:0] + TICK_BIAS;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SCALE;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      load_ff <= load_in;
   end

   assign done       = done_ff;
   assign load_value = load_ff;

endmodule

FILE: hdl/game_port_axis_timer.sv
// Game port with one-shot timers per joystick axis. A tick or read transaction
// goes from idle to the response state, which registers its response once the
// output register is free. A write passes the load and wait states per present
// axis and the load state alone per absent axis: the load count of each axis,
// ((pos + 32768) * 100 / 65) * 11 / 1000 + 24, goes one axis at a time through a
// single shared multiplier that runs four steps per axis. A write sets all four
// timing bits; each tick decrements every running counter and clears a bit when
// its counter expires. The request side is ready only while idle, and a finished
// response waits in the output register until taken, which holds off the next one.
module game_port_axis_timer
   import gpat_pkg::*;
#(
   parameter int unsigned NUM_AXES = 4
) (
   input logic clock,
   input logic reset,
   gpat_req_if.sink   req_if,
   gpat_rsp_if.source rsp_if
);

   // only axes with a position input are ever loaded
   localparam int unsigned LOAD_AXES = (NUM_AXES < INPUT_AXES) ? NUM_AXES : INPUT_AXES;
   localparam int unsigned AXIS_W    = (LOAD_AXES > 1) ? $clog2(LOAD_AXES) : 1;

   ctl_state_type             state_ff, state_in;
   logic [AXIS_W-1:0]         axis_ff, axis_in;
   logic [3:0]                flags_ff, flags_in;
   logic [COUNT_W-1:0]        count_ff [NUM_AXES];
   logic [COUNT_W-1:0]        count_in [NUM_AXES];
   logic                      running_ff [NUM_AXES];
   logic                      running_in [NUM_AXES];
   logic [1:0]                action_ff, action_in;
   logic signed [15:0]        pos_ff [INPUT_AXES];
   logic signed [15:0]        pos_in [INPUT_AXES];
   logic [3:0]                present_ff, present_in;
   logic [7:0]                joy_ff, joy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic [3:0]                rsp_bits_ff, rsp_bits_in;

   logic                      unit_start;
   logic                      unit_done;
   logic [COUNT_W-1:0]        unit_load;
   logic signed [15:0]        sel_pos;
   logic                      sel_present;
   logic                      last_axis;
   logic                      req_take;

   // shared load calculation
   gpat_load_unit u_load (
      .clock      (clock),
      .reset      (reset),
      .start      (unit_start),
      .position   (sel_pos),
      .done       (unit_done),
      .load_value (unit_load)
   );

   // position and present bit of the axis being loaded
   always_comb begin
      sel_pos     = pos_ff[0];
      sel_present = present_ff[0];
      for (int n = 0; n < LOAD_AXES; n++) begin
         if (AXIS_W'(n) == axis_ff) begin
            sel_pos     = pos_ff[n];
            sel_present = present_ff[n];
         end
      end
   end

   assign last_axis = (axis_ff == AXIS_W'(LOAD_AXES - 1));
   assign req_take  = req_if.valid && (state_ff == CTL_IDLE);

   // sequencer: next state, counters, flags and response
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      flags_in     = flags_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      action_in    = action_ff;
      pos_in       = pos_ff;
      present_in   = present_ff;
      joy_in       = joy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_bits_in  = rsp_bits_ff;
      unit_start   = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            if (req_take) begin
               action_in  = req_if.action;
               pos_in[0]  = req_if.axis0_position;
               pos_in[1]  = req_if.axis1_position;
               pos_in[2]  = req_if.axis2_position;
               pos_in[3]  = req_if.axis3_position;
               present_in = req_if.present_mask;
               joy_in     = req_if.joystick_byte;
               state_in   = CTL_RESP;
               case (req_if.action)
                  ACT_TICK: begin
                     // decrement every running counter, expire at zero
                     for (int n = 0; n < NUM_AXES; n++) begin
                        if (running_ff[n]) begin
                           count_in[n] = count_ff[n] - COUNT_W'(1);
                           if (count_ff[n] == COUNT_W'(1)) begin
                              running_in[n] = 1'b0;
                              if (n < INPUT_AXES) begin
                                 flags_in[n] = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  ACT_WRITE: begin
                     flags_in = FLAG_NIBBLE;
                     axis_in  = '0;
                     state_in = CTL_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         CTL_LOAD: begin
            if (sel_present) begin
               unit_start = 1'b1;
               state_in   = CTL_WAIT;
            end else begin
               // absent axis stops, its bit stays set
               for (int n = 0; n < LOAD_AXES; n++) begin
                  if (AXIS_W'(n) == axis_ff) begin
                     running_in[n] = 1'b0;
                  end
               end
               if (last_axis) begin
                  state_in = CTL_RESP;
               end else begin
                  axis_in = axis_ff + AXIS_W'(1);
               end
            end
         end
         CTL_WAIT: begin
            if (unit_done) begin
               for (int n = 0; n < LOAD_AXES; n++) begin
                  if (AXIS_W'(n) == axis_ff) begin
                     count_in[n]   = unit_load;
                     running_in[n] = 1'b1;
                  end
               end
               if (last_axis) begin
                  state_in = CTL_RESP;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  state_in = CTL_LOAD;
               end
            end
         end
         CTL_RESP: begin
            // hand the transaction result to the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = flags_ff;
               rsp_data_in  = (action_ff == ACT_READ) ? ({4'b0, flags_ff} | joy_ff) : 8'd0;
               state_in     = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         axis_ff      <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NUM_AXES; n++) begin
            count_ff[n]   <= '0;
            running_ff[n] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      pos_ff      <= pos_in;
      present_ff  <= present_in;
      joy_ff      <= joy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign req_if.ready       = (state_ff == CTL_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.read_data   = rsp_data_ff;
   assign rsp_if.timing_bits = rsp_bits_ff;

   // load unit only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == CTL_WAIT))
      else $error("load unit done outside wait state");

   // an accepted write sets every timing bit
   a_write_sets_flags: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.action == ACT_WRITE))
      |=> (flags_ff == FLAG_NIBBLE))
      else $error("write did not set timing bits");

   // the running counter of axis 0 never sits at zero
   a_running_nonzero: assert property (@(posedge clock) disable iff (reset)
      running_ff[0] |-> (count_ff[0] != '0))
      else $error("running counter at zero");

   // a cleared timing bit 0 means the one-shot of axis 0 is idle
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !flags_ff[0] |-> !running_ff[0])
      else $error("timing bit clear while counter runs");

endmodule

FILE: verif/game_port_axis_timer_test.sv
`timescale 1ns / 1ps

module game_port_axis_timer_test
   import gpat_pkg::*;
();

   // action code that the port leaves unused
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // positions at the ends and middle of the signed range
   localparam logic [15:0] P_MIN  = 16'h8000;
   localparam logic [15:0] P_MAX  = 16'h7fff;
   localparam logic [15:0] P_ZERO = 16'h0000;
   localparam logic [15:0] P_NEG1 = 16'hffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] axis0;
      logic [15:0] axis1;
      logic [15:0] axis2;
      logic [15:0] axis3;
      logic [3:0]  present_mask;
      logic [7:0]  joystick_byte;
   } port_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] timing_bits;
   } port_rsp_type;

   // one row of directed stimulus, sent reps times in a row
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] axis0;
      logic [15:0] axis1;
      logic [15:0] axis2;
      logic [15:0] axis3;
      logic [3:0]  present_mask;
      logic [7:0]  joystick_byte;
      int          reps;
      bit          typed;
      logic [7:0]  read_data;
      logic [3:0]  timing_bits;
   } port_row_type;

   localparam int NUM_ROWS = 24;
   localparam port_row_type PORT_ROWS [NUM_ROWS] = '{
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00,  1, 1'b1, 8'h00, 4'h0},
      '{ACT_READ,   P_MAX,  P_MAX,  P_MAX,   P_MAX,   4'hf, 8'hff,  1, 1'b1, 8'hff, 4'h0},
      '{ACT_TICK,   P_MIN,  P_MIN,  P_MIN,   P_MIN,   4'hf, 8'hff,  1, 1'b1, 8'h00, 4'h0},
      '{ACT_UNUSED, P_MAX,  P_MAX,  P_MAX,   P_MAX,   4'hf, 8'hff,  1, 1'b1, 8'h00, 4'h0},
      '{ACT_WRITE,  P_MIN,  P_MIN,  P_MIN,   P_MIN,   4'h0, 8'hff,  1, 1'b1, 8'h00, 4'hf},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00,  1, 1'b1, 8'h0f, 4'hf},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'ha0,  1, 1'b1, 8'haf, 4'hf},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00,  1, 1'b1, 8'h00, 4'hf},
      '{ACT_WRITE,  P_MAX,  P_MAX,  P_MAX,   P_MAX,   4'hf, 8'h00,  1, 1'b1, 8'h00, 4'hf},
      '{ACT_WRITE,  P_MIN,  P_MAX,  P_MAX,   P_MAX,   4'h1, 8'h00,  1, 1'b1, 8'h00, 4'hf},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00, 23, 1'b0, 8'h00, 4'h0},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00,  1, 1'b1, 8'h00, 4'he},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00,  5, 1'b1, 8'h00, 4'he},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h01,  1, 1'b1, 8'h0f, 4'he},
      '{ACT_WRITE,  P_ZERO, P_MIN,  16'h8001, P_MAX,  4'h6, 8'h00,  1, 1'b1, 8'h00, 4'hf},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00, 24, 1'b0, 8'h00, 4'h0},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h50,  1, 1'b1, 8'h59, 4'h9},
      '{ACT_WRITE,  P_ZERO, P_NEG1, 16'h0001, 16'h4000, 4'hf, 8'h00, 1, 1'b0, 8'h00, 4'h0},
      '{ACT_UNUSED, P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h77,  1, 1'b0, 8'h00, 4'h0},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00, 60, 1'b0, 8'h00, 4'h0},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h3c,  1, 1'b0, 8'h00, 4'h0},
      '{ACT_WRITE,  16'h8123, P_MIN, 16'h80ff, P_MIN, 4'ha, 8'h00,  1, 1'b0, 8'h00, 4'h0},
      '{ACT_TICK,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'h00, 40, 1'b0, 8'h00, 4'h0},
      '{ACT_READ,   P_ZERO, P_ZERO, P_ZERO,  P_ZERO,  4'h0, 8'hc3,  1, 1'b0, 8'h00, 4'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpat_req_if req_if ();
   gpat_rsp_if rsp_if ();

   game_port_axis_timer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predicted port state
   logic [3:0]  flag_nibble;
   logic [10:0] shot_count [INPUT_AXES];
   bit          axis_active [INPUT_AXES];

   port_rsp_type pending_port_rsp [$];
   port_rsp_type oldest_rsp;
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;
   int           stall_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one-shot length in ticks for a signed axis position
   function automatic logic [10:0] one_shot_load(input logic [15:0] position);
      int unsigned biased;
      int unsigned ohms;
      int unsigned ticks;
      biased = {16'd0, position ^ 16'h8000};
      ohms   = (biased * 100) / 65;
      ticks  = (ohms * 11) / 1000;
      return 11'(ticks + 24);
   endfunction

   // advance the predicted port by one transaction
   function automatic port_rsp_type predict_port(input port_req_type item);
      port_rsp_type rsp;
      logic [15:0]  position [INPUT_AXES];
      rsp = '0;
      position[0] = item.axis0;
      position[1] = item.axis1;
      position[2] = item.axis2;
      position[3] = item.axis3;
      case (item.action)
         ACT_TICK: begin
            for (int n = 0; n < INPUT_AXES; n++) begin
               if (axis_active[n]) begin
                  shot_count[n] = shot_count[n] - 11'd1;
                  if (shot_count[n] == 11'd0) begin
                     axis_active[n] = 1'b0;
                     flag_nibble[n] = 1'b0;
                  end
               end
            end
         end
         ACT_WRITE: begin
            flag_nibble = FLAG_NIBBLE;
            for (int n = 0; n < INPUT_AXES; n++) begin
               if (item.present_mask[n]) begin
                  shot_count[n]  = one_shot_load(position[n]);
                  axis_active[n] = 1'b1;
               end else begin
                  axis_active[n] = 1'b0;
               end
            end
         end
         ACT_READ: begin
            rsp.read_data = {4'h0, flag_nibble} | item.joystick_byte;
         end
         default: begin
         end
      endcase
      rsp.timing_bits = flag_nibble;
      return rsp;
   endfunction

   // every field random; callers pick the action
   function automatic port_req_type random_item();
      port_req_type item;
      item.action        = ACT_TICK;
      item.axis0         = 16'($urandom);
      item.axis1         = 16'($urandom);
      item.axis2         = 16'($urandom);
      item.axis3         = 16'($urandom);
      item.present_mask  = 4'($urandom_range(0, 15));
      item.joystick_byte = 8'($urandom_range(0, 255));
      return item;
   endfunction

   // mostly short one-shots so bits expire within a sequence
   function automatic logic [15:0] pick_position();
      logic [15:0] position;
      case ($urandom_range(0, 19))
         0:             position = P_MIN;
         1:             position = P_MAX;
         2:             position = P_ZERO;
         3:             position = P_NEG1;
         4, 5, 6, 7, 8: position = 16'($urandom);
         default:       position = 16'($urandom_range(0, 3000)) ^ 16'h8000;
      endcase
      return position;
   endfunction

   // send one request transaction, with an optional idle burst first
   task automatic send_port_item(input port_req_type item, input bit typed,
                                 input port_rsp_type typed_rsp);
      port_rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.action         <= item.action;
      req_if.axis0_position <= item.axis0;
      req_if.axis1_position <= item.axis1;
      req_if.axis2_position <= item.axis2;
      req_if.axis3_position <= item.axis3;
      req_if.present_mask   <= item.present_mask;
      req_if.joystick_byte  <= item.joystick_byte;
      predicted = predict_port(item);
      pending_port_rsp.push_back(typed ? typed_rsp : predicted);
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // response side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left   <= $urandom_range(0, 9);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_port_rsp.size() == 0) begin
            $error("unexpected transaction: read_data %0h timing_bits %0h",
                   rsp_if.read_data, rsp_if.timing_bits);
            mismatch_count++;
         end else begin
            oldest_rsp = pending_port_rsp.pop_front();
            if (rsp_if.read_data !== oldest_rsp.read_data) begin
               $error("read_data expected %0h got %0h", oldest_rsp.read_data,
                      rsp_if.read_data);
               mismatch_count++;
            end
            if (rsp_if.timing_bits !== oldest_rsp.timing_bits) begin
               $error("timing_bits expected %0h got %0h", oldest_rsp.timing_bits,
                      rsp_if.timing_bits);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus: directed table, then write/tick sequences with some noise
   initial begin
      port_req_type item;
      port_rsp_type typed_rsp;
      int           work_items;
      int           run_len;
      int           roll;

      work_items            = 0;
      flag_nibble           = 4'h0;
      for (int n = 0; n < INPUT_AXES; n++) begin
         shot_count[n]  = 11'd0;
         axis_active[n] = 1'b0;
      end
      req_if.valid          = 1'b0;
      req_if.action         = ACT_TICK;
      req_if.axis0_position = '0;
      req_if.axis1_position = '0;
      req_if.axis2_position = '0;
      req_if.axis3_position = '0;
      req_if.present_mask   = '0;
      req_if.joystick_byte  = '0;
      rsp_if.ready          = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int r = 0; r < NUM_ROWS; r++) begin
         item.action        = PORT_ROWS[r].action;
         item.axis0         = PORT_ROWS[r].axis0;
         item.axis1         = PORT_ROWS[r].axis1;
         item.axis2         = PORT_ROWS[r].axis2;
         item.axis3         = PORT_ROWS[r].axis3;
         item.present_mask  = PORT_ROWS[r].present_mask;
         item.joystick_byte = PORT_ROWS[r].joystick_byte;
         typed_rsp.read_data   = PORT_ROWS[r].read_data;
         typed_rsp.timing_bits = PORT_ROWS[r].timing_bits;
         repeat (PORT_ROWS[r].reps) send_port_item(item, PORT_ROWS[r].typed, typed_rsp);
      end

      // random sequences; the tail runs with no idling
      while (work_items < 900) begin
         idle_on = (work_items < 780) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            item        = random_item();
            item.action = 2'($urandom_range(0, 3));
            send_port_item(item, 1'b0, '0);
            if (item.action != ACT_UNUSED) work_items++;
         end else begin
            item        = random_item();
            item.action = ACT_WRITE;
            item.axis0  = pick_position();
            item.axis1  = pick_position();
            item.axis2  = pick_position();
            item.axis3  = pick_position();
            if ($urandom_range(0, 1) == 1) item.present_mask = FLAG_NIBBLE;
            send_port_item(item, 1'b0, '0);
            work_items++;
            run_len = $urandom_range(0, 90);
            repeat (run_len) begin
               item = random_item();
               roll = $urandom_range(0, 19);
               if (roll < 16) item.action = ACT_TICK;
               else if (roll < 19) item.action = ACT_READ;
               else item.action = ACT_UNUSED;
               send_port_item(item, 1'b0, '0);
               if (item.action != ACT_UNUSED) work_items++;
            end
         end
      end
      req_if.valid <= 1'b0;

      // drain, then allow for a late stray transaction
      while (pending_port_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("game_port_axis_timer_test: clean");
      else
         $display("game_port_axis_timer_test: errors");
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("game_port_axis_timer_test: errors");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/gpat_pkg.sv
hdl/gpat_ifs.sv
hdl/gpat_load_unit.sv
hdl/game_port_axis_timer.sv
verif/game_port_axis_timer_test.sv
